// File: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and fixed-point helpers for the line clipper.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_W       = 14;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAG_W       = 2 * COORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t ONE_FX    = coord_t'(MAG_W'(1) << FRAC_W);
  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(1) << (COORD_W - 1);

  typedef enum logic [2:0] {
    STAT_OUTSIDE  = 3'd0,
    STAT_INSIDE   = 3'd1,
    STAT_HORIZ    = 3'd2,
    STAT_VERT     = 3'd3,
    STAT_CLIPPED  = 3'd4,
    STAT_REJECTED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DSTART,
    PH_DWAIT,
    PH_MUL,
    PH_WB,
    PH_DECIDE
  } phase_t;

  typedef enum logic [3:0] {
    OP_SLOPE,
    OP_H_LU,
    OP_H_LV,
    OP_H_RU,
    OP_H_RV,
    OP_G_L,
    OP_G_R,
    OP_G_T,
    OP_G_B
  } op_t;

  typedef struct packed {
    logic   ndc_mode;
    coord_t start_x;
    coord_t start_y;
    coord_t start_u;
    coord_t start_v;
    coord_t end_x;
    coord_t end_y;
    coord_t end_u;
    coord_t end_v;
  } item_t;

  typedef struct packed {
    logic [2:0] clip_status;
    coord_t     left_x;
    coord_t     left_y;
    coord_t     left_u;
    coord_t     left_v;
    coord_t     right_x;
    coord_t     right_y;
    coord_t     right_u;
    coord_t     right_v;
    coord_t     slope;
  } result_t;

  // One classified segment, ordered into left and right endpoints.
  typedef struct packed {
    status_t status;
    logic    bot_is_left;
    coord_t  lx;
    coord_t  ly;
    coord_t  lu;
    coord_t  lv;
    coord_t  rx;
    coord_t  ry;
    coord_t  ru;
    coord_t  rv;
    coord_t  dx;
    coord_t  dy;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic coord_t sat1(input logic [COORD_W:0] a);
    coord_t r;
    if (a[COORD_W] != a[COORD_W-1]) begin
      r = a[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      r = coord_t'(a[COORD_W-1:0]);
    end
    return r;
  endfunction

  function automatic coord_t add_sat(input coord_t a, input coord_t b);
    return sat1({a[COORD_W-1], a} + {b[COORD_W-1], b});
  endfunction

  function automatic coord_t sub_sat(input coord_t a, input coord_t b);
    return sat1({a[COORD_W-1], a} - {b[COORD_W-1], b});
  endfunction

  function automatic logic [COORD_W-1:0] mag(input coord_t a);
    logic [COORD_W-1:0] r;
    r = a[COORD_W-1] ? (~a + 1'b1) : a;
    return r;
  endfunction

  // Signed result from a magnitude and a sign, saturated to the coordinate range.
  function automatic coord_t from_mag(input logic [MAG_W-1:0] m, input logic neg);
    coord_t r;
    if (neg) begin
      r = (m > MAG_LIMIT) ? COORD_MIN : coord_t'(-m[COORD_W-1:0]);
    end else begin
      r = (m > MAG_LIMIT - 1'b1) ? COORD_MAX : coord_t'(m[COORD_W-1:0]);
    end
    return r;
  endfunction

  function automatic coord_t to_fx(input logic [CFG_W-1:0] v);
    return coord_t'({v, {FRAC_W{1'b0}}});
  endfunction

endpackage

// File: rtl/lcs_div.sv
// ----------------------------------------------------------------------------
// lcs_div
// Iterative fixed-point divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module lcs_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  lcs_pkg::coord_t num,
  input  lcs_pkg::coord_t den,
  output logic           done,
  output lcs_pkg::coord_t quo
);

  localparam int CW    = lcs_pkg::COORD_W;
  localparam int DW    = lcs_pkg::COORD_W + lcs_pkg::FRAC_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [CW-1:0]    rem;
  logic [DW-1:0]    dvd;
  logic [CW-1:0]    den_mag;
  logic             neg;
  logic             zdiv;
  lcs_pkg::coord_t  zval;

  logic [CW:0] rem_sh;
  logic [CW:0] rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem, dvd[DW-1]};
    ge      = rem_sh >= {1'b0, den_mag};
    rem_sub = rem_sh - {1'b0, den_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run     <= 1'b1;
        zdiv    <= (den == '0);
        cnt     <= (den == '0) ? '0 : CNT_W'(DW);
        dvd     <= {lcs_pkg::mag(num), {lcs_pkg::FRAC_W{1'b0}}};
        rem     <= '0;
        den_mag <= lcs_pkg::mag(den);
        neg     <= num[CW-1] ^ den[CW-1];
        zval    <= (num == '0) ? '0 :
                   (num[CW-1] ? lcs_pkg::COORD_MIN : lcs_pkg::COORD_MAX);
      end else if (run) begin
        if (cnt != '0) begin
          rem <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
          dvd <= {dvd[DW-2:0], ge};
          cnt <= cnt - 1'b1;
        end else begin
          run  <= 1'b0;
          done <= 1'b1;
          quo  <= zdiv ? zval :
                  lcs_pkg::from_mag({{(lcs_pkg::MAG_W-DW){1'b0}}, dvd}, neg);
        end
      end
    end
  end

endmodule

// File: rtl/lcs_queue.sv
// ----------------------------------------------------------------------------
// lcs_queue
// Short FIFO of classified segments between the front and back sections.
// ----------------------------------------------------------------------------
module lcs_queue #(
  parameter int QUEUE_DEPTH = lcs_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcs_pkg::entry_t din,
  input  logic            pop,
  output lcs_pkg::entry_t dout,
  output lcs_pkg::qstat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lcs_pkg::entry_t  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign dout       = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// File: rtl/lcs_front.sv
// ----------------------------------------------------------------------------
// lcs_front
// Accepts segments, maps NDC to screen space, orders and classifies them.
// ----------------------------------------------------------------------------
module lcs_front #(
  parameter int QUEUE_DEPTH = lcs_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  lcs_pkg::item_t              item,
  output logic                        busy,
  input  logic [lcs_pkg::CFG_W-1:0]   width,
  input  logic [lcs_pkg::CFG_W-1:0]   height,
  input  logic                        pop,
  output logic                        push,
  output lcs_pkg::entry_t             entry
);

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W = lcs_pkg::COORD_W + lcs_pkg::CFG_W + 1;
  localparam int CW     = lcs_pkg::COORD_W;

  // Items anywhere between the input and the back section; bounded by the queue size.
  logic [CNT_W-1:0] inflight;
  logic             accept;

  assign accept = start & ~busy;
  assign busy   = (inflight == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(accept) - CNT_W'(pop);
    end
  end

  function automatic lcs_pkg::coord_t half_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] h;
    lcs_pkg::coord_t          r;
    // Adding the sign bit first makes the halving round toward zero.
    rnd = {{(PROD_W-1){1'b0}}, p[PROD_W-1]};
    h   = (p + rnd) >>> 1;
    if (h[PROD_W-1:CW-1] != {(PROD_W-CW+1){h[PROD_W-1]}}) begin
      r = h[PROD_W-1] ? lcs_pkg::COORD_MIN : lcs_pkg::COORD_MAX;
    end else begin
      r = lcs_pkg::coord_t'(h[CW-1:0]);
    end
    return r;
  endfunction

  // Stage 1: offset and scale products.
  logic signed [lcs_pkg::CFG_W:0] wid_s;
  logic signed [lcs_pkg::CFG_W:0] hgt_s;
  lcs_pkg::coord_t sx0, sy0, sx1, sy1;

  logic                     s1_valid;
  lcs_pkg::item_t           s1_item;
  logic signed [PROD_W-1:0] s1_px0, s1_py0, s1_px1, s1_py1;

  always_comb begin
    wid_s = {1'b0, width};
    hgt_s = {1'b0, height};
    sx0   = lcs_pkg::add_sat(item.start_x, lcs_pkg::ONE_FX);
    sy0   = lcs_pkg::sub_sat(lcs_pkg::ONE_FX, item.start_y);
    sx1   = lcs_pkg::add_sat(item.end_x, lcs_pkg::ONE_FX);
    sy1   = lcs_pkg::sub_sat(lcs_pkg::ONE_FX, item.end_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= item;
    s1_px0  <= sx0 * wid_s;
    s1_py0  <= sy0 * hgt_s;
    s1_px1  <= sx1 * wid_s;
    s1_py1  <= sy1 * hgt_s;
  end

  // Stage 2: screen-space endpoints.
  logic            s2_valid;
  lcs_pkg::coord_t s2_x0, s2_y0, s2_u0, s2_v0, s2_x1, s2_y1, s2_u1, s2_v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_x0 <= s1_item.ndc_mode ? half_sat(s1_px0) : s1_item.start_x;
    s2_y0 <= s1_item.ndc_mode ? half_sat(s1_py0) : s1_item.start_y;
    s2_x1 <= s1_item.ndc_mode ? half_sat(s1_px1) : s1_item.end_x;
    s2_y1 <= s1_item.ndc_mode ? half_sat(s1_py1) : s1_item.end_y;
    s2_u0 <= s1_item.start_u;
    s2_v0 <= s1_item.start_v;
    s2_u1 <= s1_item.end_u;
    s2_v1 <= s1_item.end_v;
  end

  // Stage 3: ordering and classification.
  logic            end_left, end_bottom, bl;
  lcs_pkg::coord_t lx, ly, rx, ry, dx, dy, pby, pty, wfx, hfx, hm1;
  logic            outside, in_view;
  lcs_pkg::entry_t e;

  always_comb begin
    end_left   = !(s2_x0 < s2_x1);
    end_bottom = !(s2_y0 > s2_y1);
    bl         = (end_left == end_bottom);
    lx         = end_left ? s2_x1 : s2_x0;
    ly         = end_left ? s2_y1 : s2_y0;
    rx         = end_left ? s2_x0 : s2_x1;
    ry         = end_left ? s2_y0 : s2_y1;
    dx         = lcs_pkg::sub_sat(rx, lx);
    dy         = lcs_pkg::sub_sat(ry, ly);
    pby        = bl ? ly : ry;
    pty        = bl ? ry : ly;
    wfx        = lcs_pkg::to_fx(width);
    hfx        = lcs_pkg::to_fx(height);
    hm1        = lcs_pkg::sub_sat(hfx, lcs_pkg::ONE_FX);
    outside    = (pby < 0) || (pty >= hfx) || (rx < 0) || (lx >= wfx);
    in_view    = (pby < hfx) && (pty >= 0) && (lx >= 0) && (rx < wfx);

    e.bot_is_left = bl;
    e.lx = lx;
    e.ly = ly;
    e.lu = end_left ? s2_u1 : s2_u0;
    e.lv = end_left ? s2_v1 : s2_v0;
    e.rx = rx;
    e.ry = ry;
    e.ru = end_left ? s2_u0 : s2_u1;
    e.rv = end_left ? s2_v0 : s2_v1;
    e.dx = dx;
    e.dy = dy;

    if (outside) begin
      e.status = lcs_pkg::STAT_OUTSIDE;
      e.lx     = '0;
      e.ly     = '0;
      e.rx     = '0;
      e.ry     = '0;
    end else if (in_view) begin
      e.status = lcs_pkg::STAT_INSIDE;
    end else if (dy == '0 && dx != '0) begin
      e.status = lcs_pkg::STAT_HORIZ;
    end else if (dx == '0) begin
      // Vertical lines and single points only need a clamp on y.
      e.status = lcs_pkg::STAT_VERT;
      if (pty < 0) begin
        if (bl) begin
          e.ry = '0;
        end else begin
          e.ly = '0;
        end
      end
      if (pby >= hfx) begin
        if (bl) begin
          e.ly = hm1;
        end else begin
          e.ry = hm1;
        end
      end
    end else begin
      e.status = lcs_pkg::STAT_CLIPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    entry <= e;
  end

endmodule

// File: rtl/lcs_back.sv
// ----------------------------------------------------------------------------
// lcs_back
// Sequencer that forms the slope and clips one segment with a shared
// divider and multiplier, then issues the result beat.
// ----------------------------------------------------------------------------
module lcs_back (
  input  logic                      clk,
  input  logic                      rst,
  input  lcs_pkg::qstat_t           qstat,
  input  lcs_pkg::entry_t           entry,
  output logic                      pop,
  input  logic [lcs_pkg::CFG_W-1:0] width,
  input  logic [lcs_pkg::CFG_W-1:0] height,
  output logic                      done,
  output lcs_pkg::result_t          result
);

  localparam int CW = lcs_pkg::COORD_W;

  lcs_pkg::phase_t phase, phase_next;
  lcs_pkg::op_t    op, op_next;

  lcs_pkg::status_t status;
  logic             bl;
  lcs_pkg::coord_t  lx, ly, lu, lv, rx, ry, ru, rv, sdx, sdy, slope, t;
  logic [lcs_pkg::MAG_W-1:0] prod;
  logic                      prod_neg;

  lcs_pkg::coord_t dx, dy, pby, pty, wfx, hfx, wm1, hm1, mres, new_x;
  lcs_pkg::coord_t div_a, div_b, m_op, qmag;
  logic            outside, finish, reject, cont;
  logic            chk_left, chk_right, chk_top;
  logic            div_go, div_done;
  lcs_pkg::coord_t div_q;
  logic [CW-1:0]   qm;

  lcs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_a),
    .den  (div_b),
    .done (div_done),
    .quo  (div_q)
  );

  always_comb begin
    dx      = lcs_pkg::sub_sat(rx, lx);
    dy      = lcs_pkg::sub_sat(ry, ly);
    pby     = bl ? ly : ry;
    pty     = bl ? ry : ly;
    wfx     = lcs_pkg::to_fx(width);
    hfx     = lcs_pkg::to_fx(height);
    wm1     = lcs_pkg::sub_sat(wfx, lcs_pkg::ONE_FX);
    hm1     = lcs_pkg::sub_sat(hfx, lcs_pkg::ONE_FX);
    outside = (pby < 0) || (pty >= hfx) || (rx < 0) || (lx >= wfx);
    mres    = lcs_pkg::from_mag(prod >> lcs_pkg::FRAC_W, prod_neg);
    new_x   = lcs_pkg::add_sat(lx, mres);
    qm      = lcs_pkg::mag(div_q);
    qmag    = qm[CW-1] ? lcs_pkg::COORD_MAX : lcs_pkg::coord_t'(qm);
  end

  // Operand selection for the shared divider and multiplier.
  always_comb begin
    div_a = sdy;
    div_b = dx;
    m_op  = dy;
    case (op)
      lcs_pkg::OP_SLOPE: begin
        div_a = sdy;
        div_b = sdx;
      end
      lcs_pkg::OP_H_LU: begin
        div_a = lcs_pkg::sub_sat(ru, lu);
        m_op  = lcs_pkg::sub_sat('0, lx);
      end
      lcs_pkg::OP_H_LV: begin
        div_a = lcs_pkg::sub_sat(rv, lv);
        m_op  = lcs_pkg::sub_sat('0, lx);
      end
      lcs_pkg::OP_H_RU: begin
        div_a = lcs_pkg::sub_sat(ru, lu);
        m_op  = lcs_pkg::sub_sat(rx, wfx);
      end
      lcs_pkg::OP_H_RV: begin
        div_a = lcs_pkg::sub_sat(rv, lv);
        m_op  = lcs_pkg::sub_sat(rx, wfx);
      end
      lcs_pkg::OP_G_L: begin
        div_a = lcs_pkg::sub_sat('0, lx);
      end
      lcs_pkg::OP_G_R: begin
        div_a = lcs_pkg::sub_sat(wfx, lx);
      end
      lcs_pkg::OP_G_T: begin
        div_a = ly;
        div_b = dy;
        m_op  = dx;
      end
      lcs_pkg::OP_G_B: begin
        div_a = lcs_pkg::sub_sat(ly, hfx);
        div_b = dy;
        m_op  = dx;
      end
      default: begin
        div_a = sdy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lcs_pkg::PH_IDLE;
      op    <= lcs_pkg::OP_SLOPE;
    end else begin
      phase <= phase_next;
      op    <= op_next;
    end
  end

  always_comb begin
    phase_next = phase;
    op_next    = op;
    pop        = 1'b0;
    div_go     = 1'b0;
    finish     = 1'b0;
    reject     = 1'b0;
    cont       = 1'b0;
    chk_left   = 1'b0;
    chk_right  = 1'b0;
    chk_top    = 1'b0;
    case (phase)
      lcs_pkg::PH_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          op_next    = lcs_pkg::OP_SLOPE;
          phase_next = lcs_pkg::PH_DSTART;
        end
      end
      lcs_pkg::PH_DSTART: begin
        div_go     = 1'b1;
        phase_next = lcs_pkg::PH_DWAIT;
      end
      lcs_pkg::PH_DWAIT: begin
        if (div_done) begin
          phase_next = (op == lcs_pkg::OP_SLOPE) ? lcs_pkg::PH_DECIDE : lcs_pkg::PH_MUL;
        end
      end
      lcs_pkg::PH_MUL: begin
        phase_next = lcs_pkg::PH_WB;
      end
      lcs_pkg::PH_WB: begin
        phase_next = lcs_pkg::PH_DECIDE;
      end
      lcs_pkg::PH_DECIDE: begin
        case (op)
          lcs_pkg::OP_SLOPE: begin
            if (status == lcs_pkg::STAT_HORIZ) begin
              if (lx < 0) begin
                op_next = lcs_pkg::OP_H_LU;
                cont    = 1'b1;
              end else if (rx >= wfx) begin
                op_next = lcs_pkg::OP_H_RU;
                cont    = 1'b1;
              end
            end else if (status == lcs_pkg::STAT_CLIPPED) begin
              if (lx < 0) begin
                op_next = lcs_pkg::OP_G_L;
                cont    = 1'b1;
              end else begin
                chk_left = 1'b1;
              end
            end
          end
          lcs_pkg::OP_H_LU: begin
            op_next = lcs_pkg::OP_H_LV;
            cont    = 1'b1;
          end
          lcs_pkg::OP_H_LV: begin
            if (rx >= wfx) begin
              op_next = lcs_pkg::OP_H_RU;
              cont    = 1'b1;
            end
          end
          lcs_pkg::OP_H_RU: begin
            op_next = lcs_pkg::OP_H_RV;
            cont    = 1'b1;
          end
          lcs_pkg::OP_G_L: chk_left = 1'b1;
          lcs_pkg::OP_G_R: chk_right = 1'b1;
          lcs_pkg::OP_G_T: chk_top = 1'b1;
          default: begin
            cont = 1'b0;
          end
        endcase
        // The general case re-tests for a rejected line after the left and right clips.
        if (chk_left) begin
          if (outside) begin
            reject = 1'b1;
          end else if (rx >= wfx) begin
            op_next = lcs_pkg::OP_G_R;
            cont    = 1'b1;
          end else begin
            chk_right = 1'b1;
          end
        end
        if (chk_right) begin
          if (outside) begin
            reject = 1'b1;
          end else if (pty < 0) begin
            op_next = lcs_pkg::OP_G_T;
            cont    = 1'b1;
          end else begin
            chk_top = 1'b1;
          end
        end
        if (chk_top) begin
          if (pby >= hfx) begin
            op_next = lcs_pkg::OP_G_B;
            cont    = 1'b1;
          end
        end
        finish     = !cont;
        phase_next = cont ? lcs_pkg::PH_DSTART : lcs_pkg::PH_IDLE;
      end
      default: begin
        phase_next = lcs_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status <= entry.status;
      bl     <= entry.bot_is_left;
      lx     <= entry.lx;
      ly     <= entry.ly;
      lu     <= entry.lu;
      lv     <= entry.lv;
      rx     <= entry.rx;
      ry     <= entry.ry;
      ru     <= entry.ru;
      rv     <= entry.rv;
      sdx    <= entry.dx;
      sdy    <= entry.dy;
    end
    if (phase == lcs_pkg::PH_DWAIT && div_done) begin
      if (op == lcs_pkg::OP_SLOPE) begin
        slope <= div_q;
      end else if (op == lcs_pkg::OP_G_T || op == lcs_pkg::OP_G_B) begin
        t <= qmag;
      end else begin
        t <= div_q;
      end
    end
    if (phase == lcs_pkg::PH_MUL) begin
      prod     <= lcs_pkg::mag(t) * lcs_pkg::mag(m_op);
      prod_neg <= t[CW-1] ^ m_op[CW-1];
    end
    if (phase == lcs_pkg::PH_WB) begin
      case (op)
        lcs_pkg::OP_H_LU: lu <= lcs_pkg::add_sat(lu, mres);
        lcs_pkg::OP_H_LV: begin
          lv <= lcs_pkg::add_sat(lv, mres);
          lx <= '0;
        end
        lcs_pkg::OP_H_RU: ru <= lcs_pkg::sub_sat(ru, mres);
        lcs_pkg::OP_H_RV: begin
          rv <= lcs_pkg::sub_sat(rv, mres);
          rx <= wm1;
        end
        lcs_pkg::OP_G_L: begin
          ly <= lcs_pkg::add_sat(ly, mres);
          lx <= '0;
        end
        lcs_pkg::OP_G_R: begin
          ry <= lcs_pkg::add_sat(ly, mres);
          rx <= wm1;
        end
        lcs_pkg::OP_G_T: begin
          if (bl) begin
            ry <= '0;
            rx <= new_x;
          end else begin
            ly <= '0;
            lx <= new_x;
          end
        end
        lcs_pkg::OP_G_B: begin
          if (bl) begin
            ly <= hm1;
            lx <= new_x;
          end else begin
            ry <= hm1;
            rx <= new_x;
          end
        end
        default: begin
          slope <= slope;
        end
      endcase
    end
    if (finish) begin
      result.clip_status <= reject ? lcs_pkg::STAT_REJECTED : status;
      result.left_x      <= lx;
      result.left_y      <= ly;
      result.left_u      <= lu;
      result.left_v      <= lv;
      result.right_x     <= rx;
      result.right_y     <= ry;
      result.right_u     <= ru;
      result.right_v     <= rv;
      result.slope       <= slope;
    end
  end

endmodule

// File: rtl/line_clip_to_screen_top.sv
// ----------------------------------------------------------------------------
// line_clip_to_screen_top
// Clips a textured line segment to the screen rectangle in 16.16 fixed point.
// ----------------------------------------------------------------------------
// A segment is taken on a cycle with start high and busy low. The front section
// takes one segment per cycle while busy stays low, through three stages, and
// holds up to QUEUE_DEPTH segments before busy rises. The back section handles
// one segment at a time with a shared divider that produces one quotient bit
// per cycle. Each result appears for exactly one cycle with done high and must
// be captured then; done is not held, though result keeps its value until the
// next result.
module line_clip_to_screen_top #(
  parameter int QUEUE_DEPTH = lcs_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lcs_pkg::item_t                item,
  output logic                          busy,
  output logic                          done,
  output lcs_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [lcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcs_pkg::CFG_W-1:0]     cfg_data
);

  logic [lcs_pkg::CFG_W-1:0] width;
  logic [lcs_pkg::CFG_W-1:0] height;

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= lcs_pkg::WIDTH_RESET;
      height <= lcs_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lcs_pkg::REG_WIDTH:  width  <= cfg_data;
        lcs_pkg::REG_HEIGHT: height <= cfg_data;
        default: begin
          width <= width;
        end
      endcase
    end
  end

  logic            q_push;
  logic            q_pop;
  lcs_pkg::entry_t q_din;
  lcs_pkg::entry_t q_dout;
  lcs_pkg::qstat_t q_stat;

  lcs_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .width  (width),
    .height (height),
    .pop    (q_pop),
    .push   (q_push),
    .entry  (q_din)
  );

  lcs_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  lcs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (q_stat),
    .entry  (q_dout),
    .pop    (q_pop),
    .width  (width),
    .height (height),
    .done   (done),
    .result (result)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (!q_stat.full || q_pop))
    else $error("queue written while full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats on consecutive cycles");
`endif

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Line clipper testbench
// Drives directed and random segments through the screen clipper in several
// screen sizes. A bit-accurate predictor computes each expected result, and a
// scoreboard compares every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
import lcs_pkg::*;

class clip_scoreboard;
  longint unsigned scr_w = 640;
  longint unsigned scr_h = 480;
  result_t pending[$];
  int errors = 0;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;

  function longint clamp(longint a);
    return a > CMAX ? CMAX : (a < CMIN ? CMIN : a);
  endfunction

  function longint signed_of(longint unsigned m, bit neg);
    if (neg) return m > 64'd2147483648 ? CMIN : -longint'(m);
    return m > 64'd2147483647 ? CMAX : longint'(m);
  endfunction

  function longint unsigned absval(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function longint fx_mul(longint a, longint b);
    return signed_of((absval(a) * absval(b)) >> 16, (a < 0) != (b < 0));
  endfunction

  function longint fx_div(longint a, longint b);
    if (b == 0) return a > 0 ? CMAX : (a < 0 ? CMIN : 0);
    return signed_of((absval(a) << 16) / absval(b), (a < 0) != (b < 0));
  endfunction

  function bit off_screen(longint by, longint ty, longint rx, longint lx,
                          longint w, longint h);
    return by < 0 || ty >= h || rx < 0 || lx >= w;
  endfunction

  function result_t clip_segment(item_t it);
    longint x[2], y[2], u[2], v[2];
    longint w, h, dx, dy, slope, t, d;
    int l, r, b, tp;
    status_t st;
    result_t res;
    w = clamp(longint'(scr_w << 16));
    h = clamp(longint'(scr_h << 16));
    x[0] = it.start_x; y[0] = it.start_y; u[0] = it.start_u; v[0] = it.start_v;
    x[1] = it.end_x;   y[1] = it.end_y;   u[1] = it.end_u;   v[1] = it.end_v;
    if (it.ndc_mode) begin
      for (int k = 0; k < 2; k++) begin
        x[k] = clamp(clamp(x[k] + ONE) * longint'(scr_w) / 2);
        y[k] = clamp(clamp(ONE - y[k]) * longint'(scr_h) / 2);
      end
    end
    l = x[0] < x[1] ? 0 : 1;
    r = 1 - l;
    b = y[0] > y[1] ? 0 : 1;
    tp = 1 - b;
    dy = clamp(y[r] - y[l]);
    dx = clamp(x[r] - x[l]);
    slope = fx_div(dy, dx);
    if (off_screen(y[b], y[tp], x[r], x[l], w, h)) begin
      x[l] = 0; y[l] = 0; x[r] = 0; y[r] = 0;
      st = STAT_OUTSIDE;
    end else if (y[b] < h && y[tp] >= 0 && x[l] >= 0 && x[r] < w) begin
      st = STAT_INSIDE;
    end else if (dy == 0 && dx != 0) begin
      if (x[l] < 0) begin
        d = clamp(x[r] - x[l]);
        t = clamp(-x[l]);
        u[l] = clamp(u[l] + fx_mul(fx_div(clamp(u[r] - u[l]), d), t));
        v[l] = clamp(v[l] + fx_mul(fx_div(clamp(v[r] - v[l]), d), t));
        x[l] = 0;
      end
      if (x[r] >= w) begin
        d = clamp(x[r] - x[l]);
        t = clamp(x[r] - w);
        u[r] = clamp(u[r] - fx_mul(fx_div(clamp(u[r] - u[l]), d), t));
        v[r] = clamp(v[r] - fx_mul(fx_div(clamp(v[r] - v[l]), d), t));
        x[r] = clamp(w - ONE);
      end
      st = STAT_HORIZ;
    end else if (dx == 0) begin
      if (y[tp] < 0) y[tp] = 0;
      if (y[b] >= h) y[b] = clamp(h - ONE);
      st = STAT_VERT;
    end else begin
      st = STAT_CLIPPED;
      if (x[l] < 0) begin
        t = fx_div(clamp(-x[l]), dx);
        x[l] = 0;
        y[l] = clamp(y[l] + fx_mul(t, dy));
        dy = clamp(y[r] - y[l]);
        dx = clamp(x[r] - x[l]);
      end
      if (off_screen(y[b], y[tp], x[r], x[l], w, h)) begin
        st = STAT_REJECTED;
      end else begin
        if (x[r] >= w) begin
          t = fx_div(clamp(w - x[l]), dx);
          x[r] = clamp(w - ONE);
          y[r] = clamp(y[l] + fx_mul(t, dy));
          dy = clamp(y[r] - y[l]);
          dx = clamp(x[r] - x[l]);
        end
        if (off_screen(y[b], y[tp], x[r], x[l], w, h)) begin
          st = STAT_REJECTED;
        end else begin
          if (y[tp] < 0) begin
            t = clamp(longint'(absval(fx_div(y[l], dy))));
            y[tp] = 0;
            x[tp] = clamp(x[l] + fx_mul(t, dx));
            dy = clamp(y[r] - y[l]);
            dx = clamp(x[r] - x[l]);
          end
          if (y[b] >= h) begin
            t = clamp(longint'(absval(fx_div(clamp(y[l] - h), dy))));
            y[b] = clamp(h - ONE);
            x[b] = clamp(x[l] + fx_mul(t, dx));
          end
        end
      end
    end
    res.clip_status = st;
    res.left_x = x[l][31:0];  res.left_y = y[l][31:0];
    res.left_u = u[l][31:0];  res.left_v = v[l][31:0];
    res.right_x = x[r][31:0]; res.right_y = y[r][31:0];
    res.right_u = u[r][31:0]; res.right_v = v[r][31:0];
    res.slope = slope[31:0];
    return res;
  endfunction

  function void note_segment(item_t it);
    pending.push_back(clip_segment(it));
  endfunction

  function void check_result(result_t got);
    result_t want;
    logic [31:0] ev[10], av[10];
    string names[10] = '{"clip_status", "left_x", "left_y", "left_u", "left_v",
                         "right_x", "right_y", "right_u", "right_v", "slope"};
    if (pending.size() == 0) begin
      $display("%0t: result beat with nothing expected", $time);
      errors++;
      return;
    end
    want = pending.pop_front();
    ev = '{32'(want.clip_status), want.left_x, want.left_y, want.left_u, want.left_v,
           want.right_x, want.right_y, want.right_u, want.right_v, want.slope};
    av = '{32'(got.clip_status), got.left_x, got.left_y, got.left_u, got.left_v,
           got.right_x, got.right_y, got.right_u, got.right_v, got.slope};
    for (int i = 0; i < 10; i++) begin
      if (ev[i] !== av[i]) begin
        $display("%0t: %s expected %h actual %h", $time, names[i], ev[i], av[i]);
        errors++;
      end
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic start;
  item_t item;
  logic busy;
  logic done;
  result_t result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  clip_scoreboard sb = new();
  bit idle_on = 1;
  int stall_cycles = 0;

  line_clip_to_screen_top u_dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_segment(item);
      end
      if (done) begin
        sb.check_result(result);
      end
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic coord_t pix(int n);
    return coord_t'(longint'(n) <<< 16);
  endfunction

  function automatic item_t segment(bit ndc, coord_t sx, coord_t sy, coord_t ex,
                                    coord_t ey);
    item_t it;
    it.ndc_mode = ndc;
    it.start_x = sx; it.start_y = sy; it.end_x = ex; it.end_y = ey;
    it.start_u = $urandom; it.start_v = $urandom;
    it.end_u = $urandom;   it.end_v = $urandom;
    return it;
  endfunction

  // Screen coordinate biased toward the region around [0, dim].
  function automatic coord_t screen_coord(int unsigned dim);
    longint lim, v;
    lim = longint'(dim) << 16;
    case ($urandom_range(0, 9))
      0: v = $signed($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = lim;
          2: v = lim - 65536;
          3: v = -1;
          default: v = lim - 1;
        endcase
      end
      default: v = longint'($urandom) % (3 * lim + 131073) - (lim + 65536);
    endcase
    return coord_t'(sb.clamp(v));
  endfunction

  function automatic coord_t ndc_coord();
    return coord_t'($signed(32'($urandom_range(0, 32'h40000))) - 32'sh20000);
  endfunction

  function automatic item_t random_segment();
    item_t it;
    bit ndc;
    ndc = $urandom_range(0, 3) == 0;
    if (ndc) it = segment(1, ndc_coord(), ndc_coord(), ndc_coord(), ndc_coord());
    else it = segment(0, screen_coord(sb.scr_w), screen_coord(sb.scr_h),
                      screen_coord(sb.scr_w), screen_coord(sb.scr_h));
    case ($urandom_range(0, 9))
      0: it.end_y = it.start_y;
      1: it.end_x = it.start_x;
      2: begin
        it.end_x = it.start_x;
        it.end_y = it.start_y;
      end
      3: begin
        it.start_u = $signed(32'($urandom_range(0, 32'h1FFFFF))) - 32'sh100000;
        it.end_u = $signed(32'($urandom_range(0, 32'h1FFFFF))) - 32'sh100000;
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_segment(item_t it);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) sb.scr_w = val;
    else sb.scr_h = val;
  endtask

  initial begin
    int unsigned sizes[7][2] = '{'{640, 480}, '{1, 1}, '{8192, 8192}, '{16383, 16383},
                                 '{0, 0}, '{8192, 1}, '{0, 0}};
    rst = 1;
    start = 0;
    item = '0;
    cfg_we = 0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed segments at the reset screen size.
    send_segment(segment(0, pix(10), pix(20), pix(300), pix(400)));
    send_segment(segment(0, pix(-50), pix(10), pix(-5), pix(30)));
    send_segment(segment(0, pix(700), pix(10), pix(900), pix(30)));
    send_segment(segment(0, pix(10), pix(-50), pix(30), pix(-5)));
    send_segment(segment(0, pix(10), pix(500), pix(30), pix(600)));
    send_segment(segment(0, pix(-100), pix(200), pix(800), pix(200)));
    send_segment(segment(0, pix(800), pix(100), pix(300), pix(100)));
    send_segment(segment(0, pix(100), pix(-100), pix(100), pix(600)));
    send_segment(segment(0, pix(100), pix(-100), pix(100), pix(-100)));
    send_segment(segment(0, pix(-100), pix(-100), pix(800), pix(600)));
    send_segment(segment(0, pix(-100), pix(700), pix(800), pix(-200)));
    send_segment(segment(0, pix(-100), pix(10), pix(10), pix(-100)));
    send_segment(segment(0, pix(630), pix(-40), pix(700), pix(20)));
    send_segment(segment(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000));
    send_segment(segment(0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000));
    send_segment(segment(0, pix(0), pix(0), pix(639), pix(479)));
    send_segment(segment(0, pix(640), pix(480), pix(0), pix(0)));
    send_segment(segment(1, -32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000));
    send_segment(segment(1, -32'sh20000, 32'sh8000, 32'sh20000, 32'sh8000));
    send_segment(segment(1, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_segment(segment(1, 32'sh0, 32'sh18000, 32'sh0, -32'sh18000));
    begin
      item_t big;
      big = segment(0, pix(-30), pix(20), pix(700), pix(20));
      big.start_u = 32'sh7FFFFFFF; big.end_u = 32'sh80000000;
      big.start_v = 32'sh80000000; big.end_v = 32'sh7FFFFFFF;
      send_segment(big);
    end

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      if (ph == 6) begin
        sizes[ph][0] = $urandom_range(1, 8192);
        sizes[ph][1] = $urandom_range(1, 8192);
        idle_on = 0;
      end
      write_reg(REG_WIDTH, sizes[ph][0]);
      write_reg(REG_HEIGHT, sizes[ph][1]);
      for (int n = 0; n < 280; n++) begin
        // Alternate stretches with and without idle cycles, except in the last size.
        if (ph < 6) idle_on = (n / 40) % 2 == 0;
        send_segment(random_segment());
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
